[design/b64enc_pkg.sv]
// ----------------------------------------------------------------------------
// Base64 encoder package
// Word types, the job format between front and back, and the alphabet.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int unsigned JOB_CHARS        = 4;
    localparam int unsigned QUEUE_DEPTH_DEF  = 2;
    localparam logic [6:0]  PAD_CHAR         = 7'd61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [6:0] code_char;
        logic       last_char;
    } out_word_t;

    typedef struct packed {
        logic [JOB_CHARS-1:0][6:0] chars;
        logic [1:0]                last_idx;
        logic                      last_msg;
    } job_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] ch;
        ch = 7'd0;
        case (v) inside
            [6'd0:6'd25]:  ch = 7'd65 + {1'b0, v};
            [6'd26:6'd51]: ch = 7'd71 + {1'b0, v};
            [6'd52:6'd61]: ch = {1'b0, v} - 7'd4;
            6'd62:         ch = 7'd43;
            default:       ch = 7'd47;
        endcase
        return ch;
    endfunction

endpackage

[design/b64enc_front.sv]
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Tracks the group phase and leftover bits and turns each byte into a job.
// ----------------------------------------------------------------------------
module b64enc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  b64enc_pkg::in_word_t s_data,
    output logic                 job_valid,
    input  logic                 job_ready,
    output b64enc_pkg::job_t     job_data
);
    import b64enc_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic [1:0] ph;
    logic [1:0] nph;
    logic [3:0] nleft;
    logic [7:0] b;
    logic       accept;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;
    assign b         = s_data.data_byte;
    assign ph        = (phase_reg == 2'd3) ? 2'd0 : phase_reg;

    always_comb begin
        job_data          = '0;
        nph               = 2'd0;
        nleft             = 4'd0;
        case (ph)
            2'd1: begin
                job_data.chars[0] = sextet_char({left_reg[1:0], b[7:4]});
                nleft             = b[3:0];
                nph               = 2'd2;
            end
            2'd2: begin
                job_data.chars[0] = sextet_char({left_reg, b[7:6]});
                job_data.chars[1] = sextet_char(b[5:0]);
                job_data.last_idx = 2'd1;
            end
            default: begin
                job_data.chars[0] = sextet_char(b[7:2]);
                nleft             = {2'b00, b[1:0]};
                nph               = 2'd1;
            end
        endcase
        job_data.last_msg = s_data.last_byte;
        if (s_data.last_byte) begin
            if (nph == 2'd1) begin
                job_data.chars[1] = sextet_char({nleft[1:0], 4'b0000});
                job_data.chars[2] = PAD_CHAR;
                job_data.chars[3] = PAD_CHAR;
                job_data.last_idx = 2'd3;
            end else if (nph == 2'd2) begin
                job_data.chars[1] = sextet_char({nleft, 2'b00});
                job_data.chars[2] = PAD_CHAR;
                job_data.last_idx = 2'd2;
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        if (accept) begin
            phase_next = s_data.last_byte ? 2'd0 : nph;
            left_next  = s_data.last_byte ? 4'd0 : nleft;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            left_reg  <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

[design/b64enc_queue.sv]
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short register queue that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
module b64enc_queue #(
    parameter int unsigned DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  b64enc_pkg::job_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output b64enc_pkg::job_t pop_data
);
    import b64enc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/b64enc_back.sv]
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Serializes each job into characters via an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64enc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  b64enc_pkg::job_t      job_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64enc_pkg::out_word_t m_data
);
    import b64enc_pkg::*;

    job_t       job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;
    logic       out_free;
    logic       at_end;

    assign out_free  = !m_valid_reg || m_ready;
    assign at_end    = (idx_reg == job_reg.last_idx);
    assign job_ready = !busy_reg || (out_free && at_end);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        job_next     = job_reg;
        idx_next     = idx_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                m_data_next.code_char = job_reg.chars[idx_reg];
                m_data_next.last_char = job_reg.last_msg && at_end;
                idx_next              = idx_reg + 1'b1;
                if (at_end) begin
                    busy_next = 1'b0;
                end
            end
        end
        if (job_valid && job_ready) begin
            job_next  = job_data;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[design/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard-alphabet Base64 characters with padding.
// ----------------------------------------------------------------------------
// A byte's job passes the queue, the job register and then the output register.
// Throughput: one character per cycle while m_ready allows, so a three-byte group
// yields four characters; a last byte yields up to four with its flush and padding.
// Bytes are taken every cycle while the job queue has room.
// Reset clears the group phase, the leftover bits, the queue and the output valid flag.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b64enc_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64enc_pkg::out_word_t m_data
);
    import b64enc_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    b64enc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64enc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
